>>> rtl/core/scs_pkg.sv
// Shared types and constants for the shortest common supersequence block.
// Holds the microcode word layout, datapath actions and jump conditions.
// Used by every module under rtl/core.
package scs_pkg;

    localparam int MAX_LEN = 32;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int TAB_W   = 2 * IDX_W;
    localparam int N_W     = $clog2(2 * MAX_LEN + 1);
    localparam int BUF_W   = $clog2(2 * MAX_LEN);

    localparam logic [1:0] MODE_APPEND_A = 2'd0;
    localparam logic [1:0] MODE_APPEND_B = 2'd1;
    localparam logic [1:0] MODE_RUN      = 2'd2;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_IDLE      = 4'd0;
    localparam t_pc PC_SETUP     = 4'd1;
    localparam t_pc PC_ROW       = 4'd2;
    localparam t_pc PC_READ      = 4'd3;
    localparam t_pc PC_CELL      = 4'd4;
    localparam t_pc PC_ROW_END   = 4'd5;
    localparam t_pc PC_TB_INIT   = 4'd6;
    localparam t_pc PC_TB_READ   = 4'd7;
    localparam t_pc PC_TB_STEP   = 4'd8;
    localparam t_pc PC_LO_READ   = 4'd9;
    localparam t_pc PC_LO_STEP   = 4'd10;
    localparam t_pc PC_EMIT_INIT = 4'd11;
    localparam t_pc PC_EMIT_READ = 4'd12;
    localparam t_pc PC_EMIT      = 4'd13;
    localparam t_pc PC_EMIT_NEXT = 4'd14;
    localparam t_pc PC_RETURN    = 4'd15;

    typedef enum logic [3:0] {
        A_NOP,
        A_IDLE,
        A_SETUP,
        A_ROW,
        A_CELL,
        A_ROW_END,
        A_TB_INIT,
        A_TB_STEP,
        A_LO_STEP,
        A_EMIT_INIT,
        A_EMIT
    } t_action;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_RUN,
        C_EMPTY,
        C_J_MORE,
        C_I_MORE,
        C_IJ_ZERO,
        C_BOTH_ZERO,
        C_N_ZERO,
        C_OUT_BUSY,
        C_K_MORE
    } t_cond;

    typedef struct packed {
        t_action action;
        t_cond   cond;
        t_pc     target;
    } t_uword;

    typedef struct packed {
        logic run;
        logic empty;
        logic j_more;
        logic i_more;
        logic ij_zero;
        logic both_zero;
        logic n_zero;
        logic out_busy;
        logic k_more;
    } t_status;

endpackage

>>> rtl/core/scs_ucode_rom.sv
// Control store: one microcode word per step of the supersequence program.
// Depends on scs_pkg for the word layout and step addresses.
module scs_ucode_rom
    import scs_pkg::*;
(
    input  t_pc    i_pc,
    output t_uword o_uword
);

    always_comb begin
        unique case (i_pc)
            PC_IDLE:      o_uword = '{A_IDLE,      C_NO_RUN,    PC_IDLE};
            PC_SETUP:     o_uword = '{A_SETUP,     C_EMPTY,     PC_TB_INIT};
            PC_ROW:       o_uword = '{A_ROW,       C_NEVER,     PC_IDLE};
            PC_READ:      o_uword = '{A_NOP,       C_NEVER,     PC_IDLE};
            PC_CELL:      o_uword = '{A_CELL,      C_J_MORE,    PC_READ};
            PC_ROW_END:   o_uword = '{A_ROW_END,   C_I_MORE,    PC_ROW};
            PC_TB_INIT:   o_uword = '{A_TB_INIT,   C_NEVER,     PC_IDLE};
            PC_TB_READ:   o_uword = '{A_NOP,       C_IJ_ZERO,   PC_LO_READ};
            PC_TB_STEP:   o_uword = '{A_TB_STEP,   C_ALWAYS,    PC_TB_READ};
            PC_LO_READ:   o_uword = '{A_NOP,       C_BOTH_ZERO, PC_EMIT_INIT};
            PC_LO_STEP:   o_uword = '{A_LO_STEP,   C_ALWAYS,    PC_LO_READ};
            PC_EMIT_INIT: o_uword = '{A_EMIT_INIT, C_N_ZERO,    PC_IDLE};
            PC_EMIT_READ: o_uword = '{A_NOP,       C_NEVER,     PC_IDLE};
            PC_EMIT:      o_uword = '{A_EMIT,      C_OUT_BUSY,  PC_EMIT};
            PC_EMIT_NEXT: o_uword = '{A_NOP,       C_K_MORE,    PC_EMIT_READ};
            PC_RETURN:    o_uword = '{A_NOP,       C_ALWAYS,    PC_IDLE};
            default:      o_uword = '{A_NOP,       C_ALWAYS,    PC_IDLE};
        endcase
    end

endmodule

>>> rtl/core/scs_seq.sv
// Step counter of the microcode sequencer with conditional jumps.
// Depends on scs_pkg and scs_ucode_rom.
module scs_seq
    import scs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_uword  o_uword
);

    t_pc    r_pc;
    t_pc    n_pc;
    logic   take;
    t_uword uword;

    scs_ucode_rom u_rom (
        .i_pc    (r_pc),
        .o_uword (uword)
    );

    always_comb begin
        case (uword.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_RUN:    take = !i_status.run;
            C_EMPTY:     take = i_status.empty;
            C_J_MORE:    take = i_status.j_more;
            C_I_MORE:    take = i_status.i_more;
            C_IJ_ZERO:   take = i_status.ij_zero;
            C_BOTH_ZERO: take = i_status.both_zero;
            C_N_ZERO:    take = i_status.n_zero;
            C_OUT_BUSY:  take = i_status.out_busy;
            C_K_MORE:    take = i_status.k_more;
            default:     take = 1'b0;
        endcase
    end

    always_comb begin
        n_pc = take ? uword.target : t_pc'(r_pc + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = uword;

endmodule

>>> rtl/core/scs_dpath.sv
// Datapath: string stores, LCS length table, result buffer and output register.
// Carries out the action of each microcode word; depends on scs_pkg.
module scs_dpath
    import scs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_uword     i_uword,
    output t_status    o_status,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic [1:0] i_s_tuser,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,
    output logic       o_m_tlast
);

    logic [7:0]       mem_a   [MAX_LEN];
    logic [7:0]       mem_b   [MAX_LEN];
    logic [LEN_W-1:0] mem_lcs [2**TAB_W];
    logic [7:0]       mem_buf [2*MAX_LEN];

    logic [LEN_W-1:0] r_len_a, r_len_b;
    logic [LEN_W-1:0] r_i, r_j;
    logic [LEN_W-1:0] r_left, r_diag;
    logic [N_W-1:0]   r_n, r_k;
    logic [7:0]       r_a_q, r_b_q, r_buf_q;
    logic [LEN_W-1:0] r_up_q, r_left_q;
    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_last;

    logic [LEN_W-1:0] n_i, n_j, n_left, n_diag;
    logic [N_W-1:0]   n_n, n_k;

    t_action          act;
    logic             s_acc, m_acc, out_busy, out_load;
    logic             eq;
    logic [LEN_W-1:0] i_m1, i_m2, j_m1, j_m2;
    logic [LEN_W-1:0] up_v, lf_v, cell_v;
    logic             push_en;
    logic [7:0]       push_char;
    logic             cell_we;
    logic [TAB_W-1:0] wr_addr, up_addr, lf_addr;
    logic [N_W-1:0]   k_m1;

    assign act      = i_uword.action;
    assign s_acc    = i_s_tvalid && (act == A_IDLE);
    assign m_acc    = r_out_valid && i_m_tready;
    assign out_busy = r_out_valid && !i_m_tready;
    assign out_load = (act == A_EMIT) && !out_busy;

    assign i_m1 = r_i - LEN_W'(1);
    assign i_m2 = r_i - LEN_W'(2);
    assign j_m1 = r_j - LEN_W'(1);
    assign j_m2 = r_j - LEN_W'(2);
    assign k_m1 = r_k - N_W'(1);

    assign wr_addr = {i_m1[IDX_W-1:0], j_m1[IDX_W-1:0]};
    assign up_addr = {i_m2[IDX_W-1:0], j_m1[IDX_W-1:0]};
    assign lf_addr = {i_m1[IDX_W-1:0], j_m2[IDX_W-1:0]};

    // Row zero and column zero of the table are all zero and never stored.
    assign eq   = (r_a_q == r_b_q);
    assign up_v = (r_i == LEN_W'(1)) ? '0 : r_up_q;
    assign lf_v = (r_j == LEN_W'(1)) ? '0 : r_left_q;

    always_comb begin
        if (eq) begin
            cell_v = r_diag + LEN_W'(1);
        end else if (up_v > r_left) begin
            cell_v = up_v;
        end else begin
            cell_v = r_left;
        end
    end

    always_comb begin
        n_i       = r_i;
        n_j       = r_j;
        n_left    = r_left;
        n_diag    = r_diag;
        n_n       = r_n;
        n_k       = r_k;
        push_en   = 1'b0;
        push_char = r_a_q;
        cell_we   = 1'b0;
        unique case (act)
            A_SETUP: begin
                n_i = LEN_W'(1);
            end
            A_ROW: begin
                n_j    = LEN_W'(1);
                n_left = '0;
                n_diag = '0;
            end
            A_CELL: begin
                cell_we = 1'b1;
                n_left  = cell_v;
                n_diag  = up_v;
                n_j     = r_j + LEN_W'(1);
            end
            A_ROW_END: begin
                n_i = r_i + LEN_W'(1);
            end
            A_TB_INIT: begin
                n_i = r_len_a;
                n_j = r_len_b;
                n_n = '0;
            end
            A_TB_STEP: begin
                push_en = 1'b1;
                if (eq) begin
                    n_i = i_m1;
                    n_j = j_m1;
                end else if (up_v > lf_v) begin
                    n_i = i_m1;
                end else begin
                    push_char = r_b_q;
                    n_j       = j_m1;
                end
                n_n = r_n + N_W'(1);
            end
            A_LO_STEP: begin
                push_en = 1'b1;
                if (r_i != '0) begin
                    n_i = i_m1;
                end else begin
                    push_char = r_b_q;
                    n_j       = j_m1;
                end
                n_n = r_n + N_W'(1);
            end
            A_EMIT_INIT: begin
                n_k = r_n;
            end
            A_EMIT: begin
                if (out_load) begin
                    n_k = k_m1;
                end
            end
            A_NOP, A_IDLE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_left <= n_left;
        r_diag <= n_diag;
        r_n    <= n_n;
        r_k    <= n_k;
    end

    // String stores: append while idle, read at the current i and j every cycle.
    always_ff @(posedge i_clk) begin
        if (s_acc && (i_s_tuser == MODE_APPEND_A) && (r_len_a < LEN_W'(MAX_LEN))) begin
            mem_a[r_len_a[IDX_W-1:0]] <= i_s_tdata;
        end
        r_a_q <= mem_a[i_m1[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && (i_s_tuser == MODE_APPEND_B) && (r_len_b < LEN_W'(MAX_LEN))) begin
            mem_b[r_len_b[IDX_W-1:0]] <= i_s_tdata;
        end
        r_b_q <= mem_b[j_m1[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            mem_lcs[wr_addr] <= cell_v;
        end
        r_up_q   <= mem_lcs[up_addr];
        r_left_q <= mem_lcs[lf_addr];
    end

    // The trace-back fills the buffer in reverse; emission reads it back down.
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            mem_buf[r_n[BUF_W-1:0]] <= push_char;
        end
        r_buf_q <= mem_buf[k_m1[BUF_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a <= '0;
            r_len_b <= '0;
        end else if (act == A_EMIT_INIT) begin
            r_len_a <= '0;
            r_len_b <= '0;
        end else if (s_acc) begin
            if ((i_s_tuser == MODE_APPEND_A) && (r_len_a < LEN_W'(MAX_LEN))) begin
                r_len_a <= r_len_a + LEN_W'(1);
            end
            if ((i_s_tuser == MODE_APPEND_B) && (r_len_b < LEN_W'(MAX_LEN))) begin
                r_len_b <= r_len_b + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_char <= r_buf_q;
            r_out_last <= (r_k == N_W'(1));
        end
    end

    always_comb begin
        o_status.run       = s_acc && (i_s_tuser == MODE_RUN);
        o_status.empty     = (r_len_a == '0) || (r_len_b == '0);
        o_status.j_more    = (r_j != r_len_b);
        o_status.i_more    = (r_i != r_len_a);
        o_status.ij_zero   = (r_i == '0) || (r_j == '0);
        o_status.both_zero = (r_i == '0) && (r_j == '0);
        o_status.n_zero    = (r_n == '0);
        o_status.out_busy  = out_busy;
        o_status.k_more    = (r_k != '0);
    end

    assign o_s_tready = (act == A_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;

    a_cell_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (act == A_CELL) |-> ((r_i != '0) && (r_i <= r_len_a) &&
                             (r_j != '0) && (r_j <= r_len_b)))
        else $error("table cell written outside the loaded strings");

    a_buf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_en |-> ((r_n < N_W'(2 * MAX_LEN)) && !((r_i == '0) && (r_j == '0))))
        else $error("result buffer push past the end of both strings");

    a_len_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (act == A_EMIT_INIT) |=> ((r_len_a == '0) && (r_len_b == '0)))
        else $error("string lengths not cleared after a run");

    a_last_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_k == N_W'(1))) |=> (r_out_last && (r_k == '0)))
        else $error("final character not marked last");

endmodule

>>> rtl/core/shortest_common_supersequence.sv
// Shortest common supersequence of two byte strings, top level.
// Beats with tuser 0 or 1 append a byte to the first or second string (up to
// 32 each; further bytes are dropped, tuser 3 is ignored). A beat with tuser 2
// starts a run: a microcoded sequencer fills the LCS length table row by row
// (per cell one table read, then compute and write), traces back with a read
// and a step per character, then emits the supersequence with a read, an emit
// and a next step per beat, waiting in the emit step while the sink stalls.
// A run on two strings of lengths la and lb gives n output characters (n at
// most la + lb); the input is ready again once the sequencer has passed the
// emit-next and return steps after the last beat is in the output register.
// Both lengths are cleared by each run; two empty strings give no output beats.
module shortest_common_supersequence
    import scs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_in
    input  logic [1:0] i_s_axis_tuser,   // [1:0] mode
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] char_out
    output logic       o_m_axis_tlast
);

    t_uword  uword;
    t_status status;

    scs_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_uword  (uword)
    );

    scs_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_uword    (uword),
        .o_status   (status),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast)
    );

endmodule
